@@ rtl/bounded_stack_with_max_defines.svh @@
// assertion macros for the bounded stack with running maximum
// included by the modules that carry concurrent checks; no other dependencies
`ifndef BOUNDED_STACK_WITH_MAX_DEFINES_SVH
`define BOUNDED_STACK_WITH_MAX_DEFINES_SVH
`ifndef SYNTH
// check that is skipped while reset is high
`define BSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bounded stack check failed");
// check that also holds while reset is high
`define BSM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("bounded stack check failed");
`else
`define BSM_ASSERT(label, clk, rst, prop)
`define BSM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/bsm_pkg.sv @@
// shared constants, types and codes of the bounded stack with running maximum
// no dependencies; imported by bsm_front, bsm_back and the top level, not by bsm_ram
package bsm_pkg;

   // stack geometry
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // command queue between front and back
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   // command codes
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_MAX  = 2'd2,
      OP_DUMP = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // decoded command as it travels through the queue
   typedef struct packed {
      op_type               op;
      logic [WORD_BITS-1:0] value;
   } cmd_type;

endpackage

@@ rtl/bsm_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bsm_ram #(
   parameter int  WIDTH     = 32,
   parameter int  DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port, read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bsm_front.sv @@
// front end: accepts command transactions, decodes them and queues them
// depends on bsm_pkg and bounded_stack_with_max_defines.svh
`include "bounded_stack_with_max_defines.svh"
module bsm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic signed [31:0]   req_push_value,
   output logic                 q_valid,
   input  logic                 q_pop,
   output bsm_pkg::cmd_type     q_cmd
);
   import bsm_pkg::*;

   cmd_type              slot_ff [QDEPTH];
   cmd_type              dec_cmd;
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] q_count_ff, q_count_in;
   logic                 q_push;

   // decode: command code and word at stored width
   always_comb begin
      dec_cmd.op    = op_type'(req_kind);
      dec_cmd.value = WORD_BITS'(req_push_value);
   end

   // queue handshake
   assign req_stall = (q_count_ff == QCNT_BITS'(QDEPTH));
   assign q_push    = req_valid && !req_stall;
   assign q_valid   = (q_count_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({q_push, q_pop})
         2'b10:   q_count_in = q_count_ff + 1'b1;
         2'b01:   q_count_in = q_count_ff - 1'b1;
         default: q_count_in = q_count_ff;
      endcase
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   // queue slots
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

   `BSM_ASSERT(a_queue_bounded, clock, reset, q_count_ff <= QCNT_BITS'(QDEPTH))
   `BSM_ASSERT(a_no_pop_when_empty, clock, reset, q_pop |-> q_count_ff != '0)
   `BSM_ASSERT(a_push_fills, clock, reset,
      (q_push && !q_pop) |=> q_count_ff == $past(q_count_ff) + 1'b1)

endmodule

@@ rtl/bsm_back.sv @@
// back end: executes queued commands on the entry ram and running-max stack
// depends on bsm_pkg, bsm_ram and bounded_stack_with_max_defines.svh
`include "bounded_stack_with_max_defines.svh"
module bsm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  bsm_pkg::cmd_type     q_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_result_value,
   output logic                 rsp_last,
   output logic [4:0]           rsp_fill_count
);
   import bsm_pkg::*;

   typedef enum logic {
      S_RUN  = 1'b0,
      S_DUMP = 1'b1
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic signed [WORD_BITS-1:0]  max_ff [DEPTH];

   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic signed [WORD_BITS-1:0]  rsp_word_ff, rsp_word_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [CNT_BITS-1:0]          rsp_count_ff;
   logic                         rsp_load;

   logic                         adv;
   logic                         is_empty, is_full;
   logic [IDX_BITS-1:0]          top_idx, push_idx;
   logic signed [WORD_BITS-1:0]  cmd_value, top_max, new_max, dump_word;
   logic                         wr_en, rd_en;
   logic [IDX_BITS-1:0]          rd_addr;
   logic [WORD_BITS-1:0]         rd_data;

   // entry store
   bsm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (push_idx),
      .wr_data (q_cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stack status and running maximum
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_BITS'(DEPTH));
   assign top_idx   = IDX_BITS'(count_ff - 1'b1);
   assign push_idx  = IDX_BITS'(count_ff);
   assign cmd_value = q_cmd.value;
   assign dump_word = rd_data;
   assign top_max   = max_ff[top_idx];
   assign new_max   = (is_empty || (cmd_value > top_max)) ? cmd_value : top_max;
   assign q_pop     = (state_ff == S_RUN) && q_valid && adv;
   assign rsp_load  = adv && rsp_valid_in;

   // command execution and dump sequencing
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = adv ? 1'b0 : rsp_valid_ff;
      rsp_status_in = STAT_OK;
      rsp_word_in   = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      case (state_ff)
         S_RUN: begin
            if (q_pop) begin
               rsp_valid_in = 1'b1;
               case (q_cmd.op)
                  OP_PUSH: begin
                     if (is_full) begin
                        rsp_status_in = STAT_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_UNDERFLOW;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_MAX: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_word_in = top_max;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        // fetch the bottom entry, results follow from the dump state
                        rsp_valid_in = 1'b0;
                        state_in     = S_DUMP;
                        idx_in       = '0;
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = dump_word;
               rsp_last_in  = (idx_ff == top_idx);
               if (idx_ff == top_idx) begin
                  state_in = S_RUN;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // running-max stack and result payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         max_ff[push_idx] <= new_max;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_count_ff  <= count_in;
      end
   end

   // result transaction ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = 32'(rsp_word_ff);
   assign rsp_last         = rsp_last_ff;
   assign rsp_fill_count   = 5'(rsp_count_ff);

   `BSM_ASSERT(a_dump_not_empty, clock, reset, (state_ff == S_DUMP) |-> !is_empty)
   `BSM_ASSERT(a_inner_result_in_dump, clock, reset,
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == S_DUMP))
   `BSM_ASSERT(a_dump_keeps_count, clock, reset,
      (state_ff == S_DUMP) |=> (count_ff == $past(count_ff)))

endmodule

@@ rtl/bounded_stack_with_max.sv @@
// top level of the bounded stack of signed words with running maximum
// depends on bsm_pkg, bsm_front, bsm_back and bsm_ram
//
// usage:
//   req channel: one command transaction per accepted req_valid with req_stall
//   low; req_kind selects push, pop, max query or dump, req_push_value is
//   the word for a push.
//   rsp channel: one result transaction per accepted rsp_valid with rsp_stall
//   low; rsp_status, rsp_result_value, rsp_last and rsp_fill_count.
//   push, pop and max give one result with rsp_last set; a dump gives one
//   result per stored entry, bottom first, rsp_last on the top entry, or a
//   single empty result when nothing is stored.
// order: an accepted command waits in the queue, the back end pops and executes it
//   and registers its result; dump results come from registered entry ram reads.
// throughput: one push, pop or max per cycle while rsp_stall is low, set by the
//   back end executing one queued command per cycle; during a dump the back end
//   takes no new command until the top entry result is loaded, one ram read per entry.
// reset: synchronous, clears the stack to empty and drops queued commands.
// stall: a stalled result holds its register; the back end waits and the
//   two-entry command queue keeps accepting until it is full, then req_stall.
module bounded_stack_with_max (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic signed [31:0]   req_push_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_result_value,
   output logic                 rsp_last,
   output logic [4:0]           rsp_fill_count
);
   import bsm_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // accept and decode command transactions
   bsm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd)
   );

   // execute commands and drive results
   bsm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cmd            (q_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_fill_count   (rsp_fill_count)
   );

endmodule

@@ test/bounded_stack_with_max_tb.sv @@
// self-checking testbench for bounded_stack_with_max: directed table then random commands
// depends on bsm_pkg and the bounded_stack_with_max rtl
// results checked by an in-bench stack model
module bounded_stack_with_max_tb;
   import bsm_pkg::*;

   localparam int IDLE_PCT    = 35;
   localparam int RAND_ITEMS  = 430;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   // one expected result transaction
   typedef struct {
      status_type           status;
      logic signed [31:0]   value;
      logic                 last;
      logic [4:0]           fill;
   } stack_rsp_type;

   // one row of the directed table
   typedef struct {
      op_type               kind;
      logic signed [31:0]   word;
      bit                   typed;
      stack_rsp_type        known;
   } cmd_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_kind = OP_PUSH;
   logic signed [31:0]   req_push_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic signed [31:0]   rsp_result_value;
   logic                 rsp_last;
   logic [4:0]           rsp_fill_count;

   // stack model state
   logic signed [31:0]   model_words [DEPTH];
   int unsigned          model_fill = 0;

   stack_rsp_type        pending_rsp [$];
   cmd_row_type          plan [$];
   int unsigned          error_count = 0;
   int unsigned          quiet_cycles = 0;
   bit                   calm = 1'b0;

   bounded_stack_with_max u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_fill_count   (rsp_fill_count)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic stack_rsp_type make_rsp(status_type st, logic signed [31:0] v, logic l,
                                              int unsigned fill);
      stack_rsp_type r;
      r.status = st;
      r.value  = v;
      r.last   = l;
      r.fill   = fill[4:0];
      return r;
   endfunction

   // stack model: apply one command, return the results it causes
   function automatic void stack_step(op_type kind, logic signed [31:0] word,
                                      ref stack_rsp_type outs [$]);
      logic signed [31:0] best;
      outs.delete();
      case (kind)
         OP_PUSH: begin
            if (model_fill >= DEPTH) begin
               outs.push_back(make_rsp(STAT_OVERFLOW, '0, 1'b1, model_fill));
            end else begin
               model_words[model_fill] = word;
               model_fill++;
               outs.push_back(make_rsp(STAT_OK, '0, 1'b1, model_fill));
            end
         end
         OP_POP: begin
            if (model_fill == 0) begin
               outs.push_back(make_rsp(STAT_UNDERFLOW, '0, 1'b1, model_fill));
            end else begin
               model_fill--;
               outs.push_back(make_rsp(STAT_OK, '0, 1'b1, model_fill));
            end
         end
         OP_MAX: begin
            if (model_fill == 0) begin
               outs.push_back(make_rsp(STAT_EMPTY, '0, 1'b1, model_fill));
            end else begin
               best = model_words[0];
               for (int i = 1; i < model_fill; i++)
                  if (model_words[i] > best) best = model_words[i];
               outs.push_back(make_rsp(STAT_OK, best, 1'b1, model_fill));
            end
         end
         default: begin
            if (model_fill == 0) begin
               outs.push_back(make_rsp(STAT_EMPTY, '0, 1'b1, model_fill));
            end else begin
               for (int i = 0; i < model_fill; i++)
                  outs.push_back(make_rsp(STAT_OK, model_words[i], i + 1 == model_fill,
                                          model_fill));
            end
         end
      endcase
   endfunction

   // directed table rows
   task automatic add_row(op_type kind, logic signed [31:0] word, bit typed = 1'b0,
                          status_type st = STAT_OK, logic signed [31:0] v = '0,
                          int unsigned fill = 0);
      cmd_row_type row;
      row.kind  = kind;
      row.word  = word;
      row.typed = typed;
      row.known = make_rsp(st, v, 1'b1, fill);
      plan.push_back(row);
   endtask

   // drive one command transaction and record what it should produce
   task automatic send_cmd(op_type kind, logic signed [31:0] word, bit typed,
                           stack_rsp_type known);
      stack_rsp_type outs [$];
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_push_value <= word;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      stack_step(kind, word, outs);
      if (typed)
         pending_rsp.push_back(known);
      else
         foreach (outs[i]) pending_rsp.push_back(outs[i]);
   endtask

   // random word with weight on the extremes and on small repeated values
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed($urandom_range(20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_kind(int unsigned item);
      int unsigned push_pct;
      int unsigned r;
      // alternate push-heavy and pop-heavy phases so the stack hits full and empty
      push_pct = ((item / 32) % 2 == 0) ? 70 : 25;
      r = $urandom_range(99);
      if (r < push_pct) return OP_PUSH;
      if (r < 88) return OP_POP;
      if (r < 94) return OP_MAX;
      return OP_DUMP;
   endfunction

   // stimulus
   initial begin
      logic signed [31:0] fill_words [14];
      stack_rsp_type      none;
      fill_words = '{32'shffff_ffff, 32'sh0, 32'sh1, 32'shffff_fffe, 32'sh5555_5555,
                     32'shaaaa_aaaa, 32'sh7fff_fffe, 32'sh8000_0001, 32'sh0000_ffff,
                     32'shffff_0000, 32'sh1234_5678, 32'sh8000_0000, 32'shffff_ffff,
                     32'sh7fff_ffff};
      none = make_rsp(STAT_OK, '0, 1'b1, 0);

      // empty stack corner cases
      add_row(OP_POP,  32'shdead_beef, 1'b1, STAT_UNDERFLOW, '0, 0);
      add_row(OP_MAX,  32'shffff_ffff, 1'b1, STAT_EMPTY, '0, 0);
      add_row(OP_DUMP, 32'sh0,         1'b1, STAT_EMPTY, '0, 0);
      // extreme words and the maximum over them
      add_row(OP_PUSH, 32'sh8000_0000, 1'b1, STAT_OK, '0, 1);
      add_row(OP_MAX,  32'sh0,         1'b1, STAT_OK, 32'sh8000_0000, 1);
      add_row(OP_PUSH, 32'sh7fff_ffff, 1'b1, STAT_OK, '0, 2);
      add_row(OP_MAX,  32'sh5a5a_5a5a, 1'b1, STAT_OK, 32'sh7fff_ffff, 2);
      add_row(OP_DUMP, 32'sh0);
      // fill to capacity, then overflow
      foreach (fill_words[i]) add_row(OP_PUSH, fill_words[i]);
      add_row(OP_PUSH, 32'sh0bad_f00d, 1'b1, STAT_OVERFLOW, '0, DEPTH);
      add_row(OP_DUMP, 32'shffff_ffff);
      add_row(OP_MAX,  32'sh0,         1'b1, STAT_OK, 32'sh7fff_ffff, DEPTH);
      add_row(OP_POP,  32'sh7fff_ffff, 1'b1, STAT_OK, '0, DEPTH - 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_cmd(plan[i].kind, plan[i].word, plan[i].typed, plan[i].known);

      for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
         // back-to-back stretch with no idling on either side
         if (n == 150) calm <= 1'b1;
         if (n == 250) calm <= 1'b0;
         send_cmd(pick_kind(n), pick_word(), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result checking and random stall on the response side
   always @(posedge clock) begin : rsp_check
      stack_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transaction: status %0d value %0d",
                   rsp_status, rsp_result_value);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value mismatch: expected %0d, actual %0d",
                      want.value, rsp_result_value);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
            if (rsp_fill_count !== want.fill) begin
               $error("fill_count mismatch: expected %0d, actual %0d",
                      want.fill, rsp_fill_count);
               error_count++;
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

@@ bounded_stack_with_max.f @@
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bsm_ram.sv
rtl/bsm_front.sv
rtl/bsm_back.sv
rtl/bounded_stack_with_max.sv
test/bounded_stack_with_max_tb.sv
